/* rtl/separable_gaussian_blur_3x3_core_defines.svh */
// assertion macros for the separable gaussian blur core
// used by the top level only; expects signals named clock and reset in scope
`ifndef SEPARABLE_GAUSSIAN_BLUR_3X3_CORE_DEFINES_SVH
`define SEPARABLE_GAUSSIAN_BLUR_3X3_CORE_DEFINES_SVH

// same-cycle implication
`define SGB_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SGB_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/sgb_pkg.sv */
// shared widths, register codes, structs and tap arithmetic for the blur core
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sgb_pkg;

   localparam int PIX_W            = 8;
   localparam int ROW_W            = 16;
   localparam int OUT_COL_W        = 10;
   localparam int FW_W             = 11;
   localparam int WEIGHT_W         = 16;
   localparam int FRAC_W           = 16;
   localparam int CSR_INDEX_W      = 4;
   localparam int CSR_DATA_W       = 16;
   localparam int MAX_LINE_DEFAULT = 1024;

   localparam int SUM_W         = PIX_W + 1;
   localparam int SIDE_PROD_W   = WEIGHT_W + SUM_W;
   localparam int CENTER_PROD_W = WEIGHT_W + PIX_W;
   localparam int TAP_SUM_W     = SIDE_PROD_W + 1;

   localparam int QUEUE_DEPTH = 16;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [FW_W-1:0]     FRAME_WIDTH_RESET   = FW_W'(640);
   localparam logic [ROW_W-1:0]    FRAME_HEIGHT_RESET  = ROW_W'(480);
   localparam logic [WEIGHT_W-1:0] SIDE_WEIGHT_RESET   = WEIGHT_W'(18285);
   localparam logic [WEIGHT_W-1:0] CENTER_WEIGHT_RESET = WEIGHT_W'(28966);

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH   = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT  = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_SIDE_WEIGHT   = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] CSR_CENTER_WEIGHT = CSR_INDEX_W'(3);

   typedef struct packed {
      logic [FW_W-1:0]     frame_width;
      logic [ROW_W-1:0]    frame_height;
      logic [WEIGHT_W-1:0] side_weight;
      logic [WEIGHT_W-1:0] center_weight;
   } cfg_type;

   // control that travels with one row-pass value
   typedef struct packed {
      logic             row_first;
      logic             last_row;
      logic             last_in;
      logic             done_a;
      logic             done_b;
      logic [ROW_W-1:0] row;
   } op_ctl_type;

   typedef struct packed {
      logic [SIDE_PROD_W-1:0]   side_prod;
      logic [CENTER_PROD_W-1:0] center_prod;
   } tap_prod_type;

   // up to two results of one row-pass value: a is row-1, b is row
   typedef struct packed {
      logic                 has_a;
      logic                 has_b;
      logic                 last_in;
      logic                 done_a;
      logic                 done_b;
      logic [PIX_W-1:0]     pix_a;
      logic [PIX_W-1:0]     pix_b;
      logic [ROW_W-1:0]     row;
      logic [OUT_COL_W-1:0] col;
   } res_type;

   typedef struct packed {
      logic                   push;
      logic                   pop;
      logic [QUEUE_CNT_W-1:0] level;
   } queue_status_type;

   function automatic tap_prod_type tap_mul(input logic [WEIGHT_W-1:0] side,
                                            input logic [WEIGHT_W-1:0] center,
                                            input logic [SUM_W-1:0]    outer_sum,
                                            input logic [PIX_W-1:0]    mid);
      tap_prod_type p;
      p.side_prod   = SIDE_PROD_W'(side) * SIDE_PROD_W'(outer_sum);
      p.center_prod = CENTER_PROD_W'(center) * CENTER_PROD_W'(mid);
      return p;
   endfunction

   // sum, drop the fraction, saturate at full scale
   function automatic logic [PIX_W-1:0] tap_sat(input tap_prod_type prod);
      logic [TAP_SUM_W-1:0]        s;
      logic [TAP_SUM_W-FRAC_W-1:0] q;
      s = TAP_SUM_W'(prod.side_prod) + TAP_SUM_W'(prod.center_prod);
      q = s[TAP_SUM_W-1:FRAC_W];
      return (|q[TAP_SUM_W-FRAC_W-1:PIX_W]) ? {PIX_W{1'b1}} : q[PIX_W-1:0];
   endfunction

endpackage

`default_nettype wire

/* rtl/separable_gaussian_blur_3x3_core.sv */
// top level of the 3x3 separable gaussian blur: config registers and stage wiring
// depends on sgb_pkg, sgb_row_pass, sgb_col_pass, sgb_out_queue and the defines header
`timescale 1ns / 1ps
`default_nettype none
`include "separable_gaussian_blur_3x3_core_defines.svh"

// 3x3 separable gaussian blur over a raster stream of 8-bit grey pixels. each
// row is filtered side/center/side, the fraction dropped and saturated to 8
// bits, then the columns of those values are filtered the same way; borders
// replicate the edge pixel. every result carries its row and column, run_last
// on the last result of the pixel that released it and frame_done on the
// frame's bottom-right pixel. rate: one pixel per cycle in ordinary rows when
// the queue has credit. a last-column pixel stalls the next pixel, since it
// releases two horizontal values and the line stores take one read-modify-write
// per cycle. results leave one per cycle through a single output register while
// rsp_stall is low, so last-row pixels (two results each) run slower and the
// last pixel of a row in the last row releases four. a 16-entry result queue
// with credit-based input flow control absorbs the bursts; rsp_valid for a
// pixel's first result rises after the row-pass, column-pass, queue and output
// registers. the two line stores need no clearing pass after reset. csr writes
// are taken at any time (csr_ready is tied high) but belong in idle periods.

module separable_gaussian_blur_3x3_core #(
   parameter int MAX_LINE = sgb_pkg::MAX_LINE_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [sgb_pkg::PIX_W-1:0]          req_pixel_in,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [sgb_pkg::PIX_W-1:0]          rsp_pixel_out,
   output logic [sgb_pkg::ROW_W-1:0]          rsp_out_row,
   output logic [sgb_pkg::OUT_COL_W-1:0]      rsp_out_col,
   output logic                               rsp_run_last,
   output logic                               rsp_frame_done,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [sgb_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [sgb_pkg::CSR_DATA_W-1:0]     csr_data
);
   import sgb_pkg::*;

   localparam int COL_W = $clog2(MAX_LINE);

   cfg_type          cfg_ff, cfg_in;

   // row pass to line stores
   logic             rd_valid;
   logic [COL_W-1:0] rd_col;
   logic             op_valid;
   logic [COL_W-1:0] op_col;
   op_ctl_type       op_ctl;
   tap_prod_type     op_prod;

   // line stores to result queue
   logic             res_valid;
   res_type          res;

   // queue back to input credit
   logic             entry_pop;
   queue_status_type q_status;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FRAME_WIDTH: begin
               cfg_in.frame_width = csr_data[FW_W-1:0];
            end
            CSR_FRAME_HEIGHT: begin
               cfg_in.frame_height = csr_data[ROW_W-1:0];
            end
            CSR_SIDE_WEIGHT: begin
               cfg_in.side_weight = csr_data[WEIGHT_W-1:0];
            end
            CSR_CENTER_WEIGHT: begin
               cfg_in.center_weight = csr_data[WEIGHT_W-1:0];
            end
            default: begin
               // writes past the register list are dropped
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width   <= FRAME_WIDTH_RESET;
         cfg_ff.frame_height  <= FRAME_HEIGHT_RESET;
         cfg_ff.side_weight   <= SIDE_WEIGHT_RESET;
         cfg_ff.center_weight <= CENTER_WEIGHT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // counters, prior pixels, horizontal tap, credit
   sgb_row_pass #(
      .MAX_LINE (MAX_LINE)
   ) u_row_pass (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_pixel_in (req_pixel_in),
      .entry_pop    (entry_pop),
      .rd_valid     (rd_valid),
      .rd_col       (rd_col),
      .op_valid     (op_valid),
      .op_col       (op_col),
      .op_ctl       (op_ctl),
      .op_prod      (op_prod)
   );

   // two line stores, read-modify-write, vertical taps
   sgb_col_pass #(
      .MAX_LINE (MAX_LINE)
   ) u_col_pass (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .rd_valid  (rd_valid),
      .rd_col    (rd_col),
      .op_valid  (op_valid),
      .op_col    (op_col),
      .op_ctl    (op_ctl),
      .op_prod   (op_prod),
      .res_valid (res_valid),
      .res       (res)
   );

   // result queue and output register
   sgb_out_queue u_out_queue (
      .clock          (clock),
      .reset          (reset),
      .push_valid     (res_valid),
      .push_entry     (res),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pixel_out  (rsp_pixel_out),
      .rsp_out_row    (rsp_out_row),
      .rsp_out_col    (rsp_out_col),
      .rsp_run_last   (rsp_run_last),
      .rsp_frame_done (rsp_frame_done),
      .entry_pop      (entry_pop),
      .status         (q_status)
   );

   // back-to-back line store accesses never hit the same column, so the
   // write back needs no forwarding
   `SGB_ASSERT_NXT(a_col_distinct, rd_valid, !rd_valid || (rd_col != $past(rd_col)), "line store column repeated on consecutive ops")

   // the credit count keeps the queue from overflowing
   `SGB_ASSERT_IMP(a_queue_room, q_status.push, q_status.level < QUEUE_CNT_W'(QUEUE_DEPTH), "result queue push while full")

   `SGB_ASSERT_IMP(a_queue_pop, q_status.pop, q_status.level != '0, "result queue pop while empty")

endmodule

`default_nettype wire

/* rtl/sgb_row_pass.sv */
// input side: raster counters, horizontal taps, credit count for the result queue
// depends on sgb_pkg
`timescale 1ns / 1ps
`default_nettype none

module sgb_row_pass #(
   parameter int  MAX_LINE = sgb_pkg::MAX_LINE_DEFAULT,
   localparam int COL_W    = $clog2(MAX_LINE)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  sgb_pkg::cfg_type            cfg,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [sgb_pkg::PIX_W-1:0]   req_pixel_in,
   input  logic                        entry_pop,
   output logic                        rd_valid,
   output logic [COL_W-1:0]            rd_col,
   output logic                        op_valid,
   output logic [COL_W-1:0]            op_col,
   output sgb_pkg::op_ctl_type         op_ctl,
   output sgb_pkg::tap_prod_type       op_prod
);
   import sgb_pkg::*;

   logic [COL_W-1:0]       col_cnt_ff, col_cnt_in;
   logic [ROW_W-1:0]       row_cnt_ff, row_cnt_in;
   logic [PIX_W-1:0]       prior_ff, prior_in;
   logic [PIX_W-1:0]       prior2_ff, prior2_in;
   logic                   pend_ff, pend_in;
   logic [COL_W-1:0]       pend_col_ff;
   logic [ROW_W-1:0]       pend_row_ff;
   logic                   pend_last_row_ff;
   logic [QUEUE_CNT_W-1:0] used_ff, used_in;

   logic                   p1_valid_ff, p1_valid_in;
   logic [COL_W-1:0]       p1_col_ff, p1_col_in;
   logic [SUM_W-1:0]       p1_sum_ff, p1_sum_in;
   logic [PIX_W-1:0]       p1_mid_ff, p1_mid_in;
   op_ctl_type             p1_ctl_ff, p1_ctl_in;

   logic                   p2_valid_ff;
   logic [COL_W-1:0]       p2_col_ff;
   op_ctl_type             p2_ctl_ff;
   tap_prod_type           p2_prod_ff;

   logic [COL_W-1:0]       last_col_idx;
   logic [ROW_W-1:0]       last_row_idx;
   logic                   last_col, last_row, first_px, accept;
   logic [ROW_W-1:0]       issue_row;
   logic                   issue_last_row, issue_last_in;

   // clamped frame limits
   always_comb begin
      if (cfg.frame_width < FW_W'(2)) begin
         last_col_idx = COL_W'(1);
      end else if (32'(cfg.frame_width) > 32'(MAX_LINE)) begin
         last_col_idx = COL_W'(MAX_LINE - 1);
      end else begin
         last_col_idx = COL_W'(cfg.frame_width - FW_W'(1));
      end
      if (cfg.frame_height < ROW_W'(2)) begin
         last_row_idx = ROW_W'(1);
      end else begin
         last_row_idx = cfg.frame_height - ROW_W'(1);
      end
   end

   assign last_col  = col_cnt_ff >= last_col_idx;
   assign last_row  = row_cnt_ff >= last_row_idx;
   assign first_px  = (col_cnt_ff == '0) && !last_col;
   assign req_stall = pend_ff || (used_ff > QUEUE_CNT_W'(QUEUE_DEPTH - 2));
   assign accept    = req_valid && !req_stall;

   // op issue: the value left of the new pixel, or the held last-column value
   always_comb begin
      p1_valid_in    = 1'b0;
      p1_col_in      = col_cnt_ff - COL_W'(1);
      p1_sum_in      = SUM_W'(prior2_ff) + SUM_W'(req_pixel_in);
      p1_mid_in      = prior_ff;
      issue_row      = row_cnt_ff;
      issue_last_row = last_row;
      issue_last_in  = !last_col;
      if (pend_ff) begin
         // prior registers already hold pixel j-1 and pixel j
         p1_valid_in    = 1'b1;
         p1_col_in      = pend_col_ff;
         p1_sum_in      = SUM_W'(prior2_ff) + SUM_W'(prior_ff);
         issue_row      = pend_row_ff;
         issue_last_row = pend_last_row_ff;
         issue_last_in  = 1'b1;
      end else if (accept && !first_px) begin
         p1_valid_in = 1'b1;
      end
      p1_ctl_in.row_first = issue_row == '0;
      p1_ctl_in.last_row  = issue_last_row;
      p1_ctl_in.last_in   = issue_last_in;
      p1_ctl_in.done_a    = ((ROW_W + 1)'(issue_row) ==
                             ((ROW_W + 1)'(last_row_idx) + (ROW_W + 1)'(1))) &&
                            (p1_col_in == last_col_idx);
      p1_ctl_in.done_b    = (issue_row == last_row_idx) && (p1_col_in == last_col_idx);
      p1_ctl_in.row       = issue_row;
   end

   always_comb begin
      col_cnt_in = col_cnt_ff;
      row_cnt_in = row_cnt_ff;
      prior_in   = prior_ff;
      prior2_in  = prior2_ff;
      pend_in    = accept && !first_px && last_col;
      if (accept) begin
         prior_in  = req_pixel_in;
         prior2_in = first_px ? req_pixel_in : prior_ff;
         if (last_col) begin
            col_cnt_in = '0;
            row_cnt_in = last_row ? '0 : row_cnt_ff + ROW_W'(1);
         end else begin
            col_cnt_in = col_cnt_ff + COL_W'(1);
         end
      end
      used_in = used_ff + QUEUE_CNT_W'(p1_valid_in) - QUEUE_CNT_W'(entry_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_cnt_ff  <= '0;
         row_cnt_ff  <= '0;
         prior_ff    <= '0;
         prior2_ff   <= '0;
         pend_ff     <= 1'b0;
         used_ff     <= '0;
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
      end else begin
         col_cnt_ff  <= col_cnt_in;
         row_cnt_ff  <= row_cnt_in;
         prior_ff    <= prior_in;
         prior2_ff   <= prior2_in;
         pend_ff     <= pend_in;
         used_ff     <= used_in;
         p1_valid_ff <= p1_valid_in;
         p2_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_col_ff      <= col_cnt_ff;
         pend_row_ff      <= row_cnt_ff;
         pend_last_row_ff <= last_row;
      end
      p1_col_ff  <= p1_col_in;
      p1_sum_ff  <= p1_sum_in;
      p1_mid_ff  <= p1_mid_in;
      p1_ctl_ff  <= p1_ctl_in;
      p2_col_ff  <= p1_col_ff;
      p2_ctl_ff  <= p1_ctl_ff;
      p2_prod_ff <= tap_mul(cfg.side_weight, cfg.center_weight, p1_sum_ff, p1_mid_ff);
   end

   assign rd_valid = p1_valid_ff;
   assign rd_col   = p1_col_ff;
   assign op_valid = p2_valid_ff;
   assign op_col   = p2_col_ff;
   assign op_ctl   = p2_ctl_ff;
   assign op_prod  = p2_prod_ff;

endmodule

`default_nettype wire

/* rtl/sgb_col_pass.sv */
// line stores with read-modify-write and the two vertical taps
// depends on sgb_pkg
`timescale 1ns / 1ps
`default_nettype none

module sgb_col_pass #(
   parameter int  MAX_LINE = sgb_pkg::MAX_LINE_DEFAULT,
   localparam int COL_W    = $clog2(MAX_LINE)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sgb_pkg::cfg_type      cfg,
   input  logic                  rd_valid,
   input  logic [COL_W-1:0]      rd_col,
   input  logic                  op_valid,
   input  logic [COL_W-1:0]      op_col,
   input  sgb_pkg::op_ctl_type   op_ctl,
   input  sgb_pkg::tap_prod_type op_prod,
   output logic                  res_valid,
   output sgb_pkg::res_type      res
);
   import sgb_pkg::*;

   logic [PIX_W-1:0] above_mem     [MAX_LINE];
   logic [PIX_W-1:0] two_above_mem [MAX_LINE];
   logic [PIX_W-1:0] above_q, two_above_q;
   logic [PIX_W-1:0] row_val;
   logic [PIX_W-1:0] two_above_wr;

   logic                 c1_valid_ff;
   op_ctl_type           c1_ctl_ff;
   logic [OUT_COL_W-1:0] c1_col_ff;
   logic [SUM_W-1:0]     c1_sum_a_ff, c1_sum_b_ff;
   logic [PIX_W-1:0]     c1_mid_a_ff, c1_mid_b_ff;

   logic                 c2_valid_ff;
   op_ctl_type           c2_ctl_ff;
   logic [OUT_COL_W-1:0] c2_col_ff;
   tap_prod_type         c2_prod_a_ff, c2_prod_b_ff;

   assign row_val      = tap_sat(op_prod);
   assign two_above_wr = op_ctl.row_first ? row_val : above_q;

   // read in the cycle before the write back of the same op
   always_ff @(posedge clock) begin
      if (rd_valid) begin
         above_q <= above_mem[rd_col];
      end
      if (op_valid) begin
         above_mem[op_col] <= row_val;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_valid) begin
         two_above_q <= two_above_mem[rd_col];
      end
      if (op_valid) begin
         two_above_mem[op_col] <= two_above_wr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_valid_ff <= 1'b0;
         c2_valid_ff <= 1'b0;
      end else begin
         c1_valid_ff <= op_valid;
         c2_valid_ff <= c1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      c1_ctl_ff    <= op_ctl;
      c1_col_ff    <= OUT_COL_W'(op_col);
      c1_sum_a_ff  <= SUM_W'(two_above_q) + SUM_W'(row_val);
      c1_mid_a_ff  <= above_q;
      c1_sum_b_ff  <= SUM_W'(above_q) + SUM_W'(row_val);
      c1_mid_b_ff  <= row_val;
      c2_ctl_ff    <= c1_ctl_ff;
      c2_col_ff    <= c1_col_ff;
      c2_prod_a_ff <= tap_mul(cfg.side_weight, cfg.center_weight, c1_sum_a_ff, c1_mid_a_ff);
      c2_prod_b_ff <= tap_mul(cfg.side_weight, cfg.center_weight, c1_sum_b_ff, c1_mid_b_ff);
   end

   always_comb begin
      res.has_a   = !c2_ctl_ff.row_first;
      res.has_b   = !c2_ctl_ff.row_first && c2_ctl_ff.last_row;
      res.last_in = c2_ctl_ff.last_in;
      res.done_a  = c2_ctl_ff.done_a;
      res.done_b  = c2_ctl_ff.done_b;
      res.pix_a   = tap_sat(c2_prod_a_ff);
      res.pix_b   = tap_sat(c2_prod_b_ff);
      res.row     = c2_ctl_ff.row;
      res.col     = c2_col_ff;
   end

   assign res_valid = c2_valid_ff;

endmodule

`default_nettype wire

/* rtl/sgb_out_queue.sv */
// result queue, serializer to one result per transfer, and output register
// depends on sgb_pkg
`timescale 1ns / 1ps
`default_nettype none

module sgb_out_queue (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push_valid,
   input  sgb_pkg::res_type                push_entry,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [sgb_pkg::PIX_W-1:0]       rsp_pixel_out,
   output logic [sgb_pkg::ROW_W-1:0]       rsp_out_row,
   output logic [sgb_pkg::OUT_COL_W-1:0]   rsp_out_col,
   output logic                            rsp_run_last,
   output logic                            rsp_frame_done,
   output logic                            entry_pop,
   output sgb_pkg::queue_status_type       status
);
   import sgb_pkg::*;

   res_type                fifo_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0] level_ff, level_in;
   logic                   second_ff, second_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]       rsp_pixel_ff, rsp_pixel_in;
   logic [ROW_W-1:0]       rsp_row_ff, rsp_row_in;
   logic [OUT_COL_W-1:0]   rsp_col_ff;
   logic                   rsp_last_ff, rsp_last_in;
   logic                   rsp_done_ff, rsp_done_in;

   res_type                head;
   logic                   not_empty, slot_free, emit, pop;

   assign head      = fifo_ff[rd_ptr_ff];
   assign not_empty = level_ff != '0;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign emit      = not_empty && head.has_a && slot_free;
   // entries without results drop out at once
   assign pop       = not_empty &&
                      (!head.has_a || (slot_free && (second_ff || !head.has_b)));

   always_comb begin
      second_in    = second_ff;
      rsp_valid_in = slot_free ? emit : rsp_valid_ff;
      rsp_pixel_in = head.pix_a;
      rsp_row_in   = head.row - ROW_W'(1);
      rsp_last_in  = head.last_in && !head.has_b;
      rsp_done_in  = head.done_a;
      if (second_ff) begin
         rsp_pixel_in = head.pix_b;
         rsp_row_in   = head.row;
         rsp_last_in  = head.last_in;
         rsp_done_in  = head.done_b;
      end
      if (emit) begin
         second_in = !second_ff && head.has_b;
      end
      level_in = level_ff + QUEUE_CNT_W'(push_valid) - QUEUE_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         level_ff     <= '0;
         second_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (push_valid) begin
            wr_ptr_ff <= wr_ptr_ff + QUEUE_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_PTR_W'(1);
         end
         level_ff     <= level_in;
         second_ff    <= second_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         fifo_ff[wr_ptr_ff] <= push_entry;
      end
      if (emit) begin
         rsp_pixel_ff <= rsp_pixel_in;
         rsp_row_ff   <= rsp_row_in;
         rsp_col_ff   <= head.col;
         rsp_last_ff  <= rsp_last_in;
         rsp_done_ff  <= rsp_done_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_out  = rsp_pixel_ff;
   assign rsp_out_row    = rsp_row_ff;
   assign rsp_out_col    = rsp_col_ff;
   assign rsp_run_last   = rsp_last_ff;
   assign rsp_frame_done = rsp_done_ff;
   assign entry_pop      = pop;

   assign status.push  = push_valid;
   assign status.pop   = pop;
   assign status.level = level_ff;

endmodule

`default_nettype wire

/* tb/sgb_checker.sv */
// checker for the separable gaussian blur core: follows pixel, register and result
// transfers, works out each blurred pixel and compares it field by field
// depends on sgb_pkg
`timescale 1ns / 1ps

module sgb_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic [sgb_pkg::PIX_W-1:0]       req_pixel_in,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [sgb_pkg::PIX_W-1:0]       rsp_pixel_out,
   input  logic [sgb_pkg::ROW_W-1:0]       rsp_out_row,
   input  logic [sgb_pkg::OUT_COL_W-1:0]   rsp_out_col,
   input  logic                            rsp_run_last,
   input  logic                            rsp_frame_done,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [sgb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sgb_pkg::CSR_DATA_W-1:0]  csr_data,
   output int                              error_count,
   output int                              due_count,
   output int                              results_checked,
   output logic                            at_frame_start
);
   import sgb_pkg::*;

   typedef struct packed {
      logic [PIX_W-1:0]     pix;
      logic [ROW_W-1:0]     row;
      logic [OUT_COL_W-1:0] col;
      logic                 run_last;
      logic                 frame_done;
   } blurred_px_t;

   blurred_px_t blurred_due[$];

   logic [FW_W-1:0]     cfg_width;
   logic [ROW_W-1:0]    cfg_height;
   logic [WEIGHT_W-1:0] side_w;
   logic [WEIGHT_W-1:0] center_w;
   int unsigned         col_pos;
   int unsigned         row_pos;
   int unsigned         eff_width;
   int unsigned         eff_height;
   logic [PIX_W-1:0]    last_px;
   logic [PIX_W-1:0]    older_px;
   // row-pass values of the previous two rows, per column
   logic [PIX_W-1:0]    rowpass_above  [MAX_LINE_DEFAULT];
   logic [PIX_W-1:0]    rowpass_above2 [MAX_LINE_DEFAULT];

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= 40) $display("%0t ns  mismatch: %s", $time, what);
   endtask

   // side*(a+b) + center*m, fraction dropped, clipped at full scale
   function automatic logic [PIX_W-1:0] gauss_tap(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] m,
                                                 input logic [PIX_W-1:0] b);
      int unsigned acc;
      acc = (int'(side_w) * (int'(a) + int'(b)) + int'(center_w) * int'(m)) >> FRAC_W;
      return (acc > 255) ? {PIX_W{1'b1}} : acc[PIX_W-1:0];
   endfunction

   task automatic add_blurred(input logic [PIX_W-1:0] px, input int unsigned r,
                              input int unsigned c);
      blurred_px_t e;
      e.pix        = px;
      e.row        = r[ROW_W-1:0];
      e.col        = c[OUT_COL_W-1:0];
      e.run_last   = 1'b0;
      e.frame_done = (r == eff_height - 1) && (c == eff_width - 1);
      blurred_due.push_back(e);
   endtask

   task automatic column_pass_value(input logic [PIX_W-1:0] v, input int unsigned c,
                                    input int unsigned r, input bit last_row);
      int unsigned      i;
      logic [PIX_W-1:0] up2;
      logic [PIX_W-1:0] up1;
      i   = (c < MAX_LINE_DEFAULT) ? c : MAX_LINE_DEFAULT - 1;
      up2 = rowpass_above2[i];
      up1 = rowpass_above[i];
      if (r == 0) begin
         rowpass_above2[i] = v;
         rowpass_above[i]  = v;
      end else begin
         add_blurred(gauss_tap(up2, up1, v), r - 1, c);
         rowpass_above2[i] = up1;
         rowpass_above[i]  = v;
      end
      // bottom edge: replicate the last row downward
      if (last_row && r != 0) add_blurred(gauss_tap(up1, v, v), r, c);
   endtask

   task automatic blur_pixel(input logic [PIX_W-1:0] p);
      int unsigned      j;
      int unsigned      r;
      int               n0;
      bit               last_col;
      bit               last_row;
      logic [PIX_W-1:0] prev;
      blurred_px_t      tail;
      eff_width  = (cfg_width < 2) ? 2 :
                   (cfg_width > MAX_LINE_DEFAULT) ? MAX_LINE_DEFAULT : cfg_width;
      eff_height = (cfg_height < 2) ? 2 : cfg_height;
      j        = col_pos;
      r        = row_pos;
      n0       = blurred_due.size();
      last_col = (j >= eff_width - 1);
      last_row = (r >= eff_height - 1);
      if (j == 0 && !last_col) begin
         older_px = p;
         last_px  = p;
      end else begin
         prev = last_px;
         column_pass_value(gauss_tap(older_px, prev, p), j - 1, r, last_row);
         older_px = prev;
         last_px  = p;
         if (last_col) column_pass_value(gauss_tap(prev, p, p), j, r, last_row);
      end
      if (blurred_due.size() > n0) begin
         tail          = blurred_due.pop_back();
         tail.run_last = 1'b1;
         blurred_due.push_back(tail);
      end
      if (last_col) begin
         col_pos = 0;
         row_pos = last_row ? 0 : r + 1;
      end else begin
         col_pos = j + 1;
      end
   endtask

   task automatic check_result();
      blurred_px_t want;
      results_checked++;
      if (blurred_due.size() == 0) begin
         report_mismatch($sformatf("result with nothing due: pixel %0d row %0d col %0d",
                                   rsp_pixel_out, rsp_out_row, rsp_out_col));
      end else begin
         want = blurred_due.pop_front();
         if (rsp_pixel_out !== want.pix)
            report_mismatch($sformatf("pixel_out at row %0d col %0d: got %0d, want %0d",
                                      want.row, want.col, rsp_pixel_out, want.pix));
         if (rsp_out_row !== want.row)
            report_mismatch($sformatf("out_row: got %0d, want %0d", rsp_out_row, want.row));
         if (rsp_out_col !== want.col)
            report_mismatch($sformatf("out_col: got %0d, want %0d", rsp_out_col, want.col));
         if (rsp_run_last !== want.run_last)
            report_mismatch($sformatf("run_last at row %0d col %0d: got %b, want %b",
                                      want.row, want.col, rsp_run_last, want.run_last));
         if (rsp_frame_done !== want.frame_done)
            report_mismatch($sformatf("frame_done at row %0d col %0d: got %b, want %b",
                                      want.row, want.col, rsp_frame_done, want.frame_done));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         blurred_due.delete();
         cfg_width       = FRAME_WIDTH_RESET;
         cfg_height      = FRAME_HEIGHT_RESET;
         side_w          = SIDE_WEIGHT_RESET;
         center_w        = CENTER_WEIGHT_RESET;
         col_pos         = 0;
         row_pos         = 0;
         last_px         = '0;
         older_px        = '0;
         error_count     = 0;
         results_checked = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FRAME_WIDTH:   cfg_width  = csr_data[FW_W-1:0];
               CSR_FRAME_HEIGHT:  cfg_height = csr_data[ROW_W-1:0];
               CSR_SIDE_WEIGHT:   side_w     = csr_data[WEIGHT_W-1:0];
               CSR_CENTER_WEIGHT: center_w   = csr_data[WEIGHT_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) blur_pixel(req_pixel_in);
         if (rsp_valid && !rsp_stall) check_result();
      end
      due_count      = blurred_due.size();
      at_frame_start = (col_pos == 0) && (row_pos == 0);
   end

endmodule

/* tb/tb_top.sv */
// top of the blur core testbench: clock, reset, pixel and register stimulus,
// result-side stalls and the verdict
// depends on sgb_pkg, separable_gaussian_blur_3x3_core and sgb_checker
`timescale 1ns / 1ps

module tb_top;
   import sgb_pkg::*;

   localparam int TIMEOUT_NS = 20_000_000;
   // drain time for the pipeline; pixels in the top row release nothing
   localparam int IDLE_TAIL  = 16;
   localparam int RANDOM_PIXELS = 300;

   // an index no register answers to
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_INDEX = CSR_INDEX_W'(12);

   // directed pixels, in the order they are sent
   localparam logic [21*8-1:0] DIRECTED_PX = {
      8'd0,   8'd255, 8'd255, 8'd0,
      8'd255, 8'd255, 8'd255, 8'd128,
      8'hA5,  8'h5A,  8'hFF,  8'h00,
      8'd1,   8'd2,   8'd4,   8'd8,  8'd16, 8'd32, 8'd64, 8'd128, 8'd255};

   typedef enum {PX_NOISE, PX_EXTREME, PX_FLAT, PX_RAMP, PX_MIDBAND} px_pattern_e;
   typedef enum {STALL_NONE, STALL_SPARSE, STALL_RUNS, STALL_ALTERNATE} stall_pattern_e;

   logic                   clock;
   logic                   reset         = 1'b1;
   logic                   req_valid     = 1'b0;
   logic                   req_stall;
   logic [PIX_W-1:0]       req_pixel_in  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall     = 1'b0;
   logic [PIX_W-1:0]       rsp_pixel_out;
   logic [ROW_W-1:0]       rsp_out_row;
   logic [OUT_COL_W-1:0]   rsp_out_col;
   logic                   rsp_run_last;
   logic                   rsp_frame_done;
   logic                   csr_valid     = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index     = '0;
   logic [CSR_DATA_W-1:0]  csr_data      = '0;

   int   error_count;
   int   due_count;
   int   results_checked;
   logic at_frame_start;

   // stimulus bookkeeping
   int          pixels_sent = 0;
   int          frames_run  = 0;
   int          reg_writes  = 0;
   int          burst_left  = 1;
   px_pattern_e px_kind     = PX_NOISE;
   logic [7:0]  px_base     = '0;
   int          px_index    = 0;

   // result-side stall pattern state
   stall_pattern_e stall_mode  = STALL_NONE;
   int             stall_phase = 0;
   int             stall_run   = 0;
   bit             stall_hold  = 1'b0;

   separable_gaussian_blur_3x3_core uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_pixel_in   (req_pixel_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pixel_out  (rsp_pixel_out),
      .rsp_out_row    (rsp_out_row),
      .rsp_out_col    (rsp_out_col),
      .rsp_run_last   (rsp_run_last),
      .rsp_frame_done (rsp_frame_done),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   sgb_checker chk (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pixel_in    (req_pixel_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_out   (rsp_pixel_out),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_col     (rsp_out_col),
      .rsp_run_last    (rsp_run_last),
      .rsp_frame_done  (rsp_frame_done),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .error_count     (error_count),
      .due_count       (due_count),
      .results_checked (results_checked),
      .at_frame_start  (at_frame_start)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #(TIMEOUT_NS);
      $display("timeout: results still due = %0d", due_count);
      $display("FAILED: results differ");
      $finish;
   end

   // result-side stalls; the pattern is redrawn at random so stalls land on
   // every phase of a row, including the row-end and last-row bursts
   always @(negedge clock) begin
      stall_phase++;
      if (stall_phase >= 150) begin
         stall_phase = 0;
         stall_mode  = stall_pattern_e'($urandom_range(0, 3));
      end
      case (stall_mode)
         STALL_NONE:   rsp_stall <= 1'b0;
         STALL_SPARSE: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_RUNS: begin
            if (stall_run == 0) begin
               stall_hold = !stall_hold;
               stall_run  = stall_hold ? $urandom_range(1, 12) : $urandom_range(1, 5);
            end
            stall_run--;
            rsp_stall <= stall_hold;
         end
         default:      rsp_stall <= stall_phase[0];
      endcase
   end

   // next pixel of the current frame's content pattern
   function automatic logic [7:0] next_pixel();
      logic [7:0] v;
      px_index++;
      case (px_kind)
         PX_NOISE:   v = 8'($urandom_range(0, 255));
         PX_EXTREME: v = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         PX_FLAT:    v = px_base;
         PX_RAMP:    v = px_base + 8'(px_index * 7);
         default:    v = 8'($urandom_range(100, 160));
      endcase
      return v;
   endfunction

   // a third near the gaussian taps, else zero, full scale, large or random
   function automatic logic [15:0] weight_choice(input logic [15:0] nominal);
      logic [15:0] w;
      case ($urandom_range(0, 5))
         0:       w = 16'h0000;
         1:       w = 16'hFFFF;
         2:       w = 16'($urandom_range(40000, 65535));
         3:       w = 16'($urandom);
         default: w = nominal + 16'($urandom_range(0, 4000)) - 16'd2000;
      endcase
      return w;
   endfunction

   // width sits in the low 11 bits; junk above it must be ignored
   function automatic logic [15:0] width_word(input int unsigned w);
      logic [15:0] d;
      d       = 16'($urandom);
      d[10:0] = w[10:0];
      return d;
   endfunction

   // one pixel transfer; valid stays up across a burst and drops for the gaps
   task automatic push_pixel(input logic [7:0] p);
      int gap;
      req_valid    <= 1'b1;
      req_pixel_in <= p;
      do @(posedge clock); while (req_stall);
      pixels_sent++;
      @(negedge clock);
      burst_left--;
      if (burst_left <= 0) begin
         gap = $urandom_range(0, 7);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 24);
      end
   endtask

   // register transfer; csr_valid is left high so writes can run back to back
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      reg_writes++;
      @(negedge clock);
   endtask

   // stop sending and wait until every due result is out, then let the
   // pipeline drain of pixels that release nothing
   task automatic settle();
      req_valid <= 1'b0;
      while (due_count != 0) @(negedge clock);
      repeat (IDLE_TAIL) @(negedge clock);
   endtask

   task automatic configure(input int unsigned w, input int unsigned h,
                            input logic [15:0] side, input logic [15:0] center,
                            input bit write_weights, input bit write_spare);
      settle();
      if (write_spare) write_reg(CSR_SPARE_INDEX, 16'($urandom));
      write_reg(CSR_FRAME_WIDTH, width_word(w));
      write_reg(CSR_FRAME_HEIGHT, h[15:0]);
      if (write_weights) begin
         write_reg(CSR_SIDE_WEIGHT, side);
         write_reg(CSR_CENTER_WEIGHT, center);
      end
      csr_valid <= 1'b0;
   endtask

   // keep sending until the frame counters wrap back to the top-left corner
   task automatic finish_frame();
      do push_pixel(next_pixel()); while (!at_frame_start);
      frames_run++;
   endtask

   task automatic push_directed(input int first, input int count);
      int k;
      for (k = first; k < first + count; k++) push_pixel(DIRECTED_PX[8*(20-k) +: 8]);
      frames_run++;
   endtask

   // random frame, mostly small; a quarter of them shrink the width and move
   // the height part way through, which can leave the counters past the new edge
   task automatic random_frame();
      int unsigned w;
      int unsigned h;
      int unsigned ew;
      int unsigned eh;
      int unsigned n;
      int unsigned k;
      case ($urandom_range(0, 9))
         0:       w = $urandom_range(0, 1);
         1:       w = $urandom_range(13, 48);
         default: w = $urandom_range(2, 12);
      endcase
      h  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 6);
      ew = (w < 2) ? 2 : w;
      eh = (h < 2) ? 2 : h;
      px_kind = px_pattern_e'($urandom_range(0, 4));
      px_base = 8'($urandom);
      configure(w, h, weight_choice(SIDE_WEIGHT_RESET), weight_choice(CENTER_WEIGHT_RESET),
                1'b1, 1'b0);
      if ($urandom_range(0, 3) == 0) begin
         n = $urandom_range(1, ew * eh - 1);
         for (k = 0; k < n; k++) push_pixel(next_pixel());
         settle();
         // only shrink the width: a wider row would read columns never filled
         write_reg(CSR_FRAME_WIDTH, width_word($urandom_range(0, ew)));
         write_reg(CSR_FRAME_HEIGHT, 16'($urandom_range(0, eh + 3)));
         csr_valid <= 1'b0;
      end
      finish_frame();
   endtask

   initial begin
      int k;
      int random_start;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // smallest frame with the reset weights, black and white corners
      configure(2, 2, '0, '0, 1'b0, 1'b0);
      push_directed(0, 4);
      // width and height below the minimum, full-scale weights saturate
      configure(0, 1, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
      push_directed(4, 4);
      // zero weights blank everything
      configure(1, 0, 16'h0000, 16'h0000, 1'b1, 1'b0);
      push_directed(8, 4);
      // 3x3 frame of single set bits ending in 255, plus a write to an unused index
      configure(3, 3, 16'd16384, 16'd32768, 1'b1, 1'b1);
      push_directed(12, 9);

      random_start = pixels_sent;
      while (pixels_sent - random_start < RANDOM_PIXELS) random_frame();

      // tallest frame setting, then cut short so the row counter is past the end
      px_kind = PX_NOISE;
      configure(5, 65535, weight_choice(SIDE_WEIGHT_RESET),
                weight_choice(CENTER_WEIGHT_RESET), 1'b1, 1'b0);
      for (k = 0; k < 17; k++) push_pixel(next_pixel());
      settle();
      write_reg(CSR_FRAME_HEIGHT, 16'd2);
      csr_valid <= 1'b0;
      finish_frame();

      // width cut mid-row leaves the column counter past the new last column
      px_kind = PX_RAMP;
      configure(10, 4, SIDE_WEIGHT_RESET, CENTER_WEIGHT_RESET, 1'b1, 1'b0);
      for (k = 0; k < 17; k++) push_pixel(next_pixel());
      settle();
      write_reg(CSR_FRAME_WIDTH, width_word(4));
      csr_valid <= 1'b0;
      finish_frame();

      // width above the line length clamps to it; the top row is then cut
      // short so the frame stays small
      px_kind = PX_NOISE;
      configure($urandom_range(1025, 2047), 2, weight_choice(SIDE_WEIGHT_RESET),
                weight_choice(CENTER_WEIGHT_RESET), 1'b1, 1'b0);
      for (k = 0; k < 40; k++) push_pixel(next_pixel());
      settle();
      write_reg(CSR_FRAME_WIDTH, width_word($urandom_range(2, 8)));
      csr_valid <= 1'b0;
      finish_frame();

      settle();
      repeat (IDLE_TAIL) @(negedge clock);

      $display("summary: %0d frames, %0d pixels in, %0d blurred pixels compared",
               frames_run, pixels_sent, results_checked);
      $display("summary: %0d register writes, small widths plus an oversize one, %s",
               reg_writes, "weights zero to full scale");
      if (due_count != 0) $display("error: %0d blurred pixels never came out", due_count);
      if (error_count == 0 && due_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+rtl
rtl/sgb_pkg.sv
rtl/sgb_row_pass.sv
rtl/sgb_col_pass.sv
rtl/sgb_out_queue.sv
rtl/separable_gaussian_blur_3x3_core.sv
tb/sgb_checker.sv
tb/tb_top.sv
